FILE: sv/sfc_pkg.sv
// Shared types and constants for the sphere frustum cull unit.
// Used by sfc_plane_lane and sphere_frustum_cull_masked_unit; depends on nothing.
`default_nettype none

package sfc_pkg;

   // Default configuration of the unit.
   localparam int NUM_PLANES_DEF = 6;
   localparam int COORD_BITS_DEF = 24;

   // Fixed field widths.
   localparam int MAX_PLANES     = 6;
   localparam int MASK_BITS      = 6;
   localparam int PLANE_IDX_BITS = 3;
   localparam int RADIUS_BITS    = 23;
   localparam int PLANE_BITS     = 64;
   localparam int NORMAL_BITS    = 12;
   localparam int OFFSET_BITS    = 28;
   localparam int CSR_IDX_BITS   = 3;

   // Offset and radius are brought to the 14 fraction bits of the products.
   localparam int SCALE_SHIFT = 10;

   // Bit positions inside a packed plane register.
   localparam int NX_LSB  = 52;
   localparam int NY_LSB  = 40;
   localparam int NZ_LSB  = 28;
   localparam int OFF_LSB = 0;

   // Classification codes.
   localparam logic [1:0] RES_INSIDE  = 2'd0;
   localparam logic [1:0] RES_PARTIAL = 2'd1;
   localparam logic [1:0] RES_OUTSIDE = 2'd2;

   // Per-stage load enables shared by the top level and the plane lanes.
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } stage_en_type;

endpackage

`default_nettype wire

FILE: sv/sfc_plane_lane.sv
// One frustum plane test: three products, the signed distance, and the compare
// against the radius, each behind a register. Depends on sfc_pkg.
`default_nettype none

module sfc_plane_lane #(
   parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF
) (
   input  wire                                  clock,
   input  wire sfc_pkg::stage_en_type           stage_en,
   input  wire [sfc_pkg::PLANE_BITS-1:0]        plane,
   input  wire signed [COORD_BITS-1:0]          center_x,
   input  wire signed [COORD_BITS-1:0]          center_y,
   input  wire signed [COORD_BITS-1:0]          center_z,
   input  wire [sfc_pkg::RADIUS_BITS-1:0]       radius_s2,
   input  wire                                  tested_s2,
   output logic                                 reject_ff,
   output logic                                 partial_ff
);

   localparam int PW = COORD_BITS + sfc_pkg::NORMAL_BITS;
   localparam int SW = COORD_BITS + 14;
   localparam int DW = ((SW > sfc_pkg::OFFSET_BITS + sfc_pkg::SCALE_SHIFT) ?
                        SW : sfc_pkg::OFFSET_BITS + sfc_pkg::SCALE_SHIFT) + 1;
   localparam int RW = sfc_pkg::RADIUS_BITS + sfc_pkg::SCALE_SHIFT + 1;

   logic signed [sfc_pkg::NORMAL_BITS-1:0] nx, ny, nz;
   logic signed [sfc_pkg::OFFSET_BITS-1:0] off;
   logic signed [PW-1:0] px_in, py_in, pz_in;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   logic signed [DW-1:0] dist_in, dist_ff;
   logic signed [DW-1:0] r_pos, r_neg;
   logic                 reject_in, partial_in;

   assign nx  = plane[sfc_pkg::NX_LSB +: sfc_pkg::NORMAL_BITS];
   assign ny  = plane[sfc_pkg::NY_LSB +: sfc_pkg::NORMAL_BITS];
   assign nz  = plane[sfc_pkg::NZ_LSB +: sfc_pkg::NORMAL_BITS];
   assign off = plane[sfc_pkg::OFF_LSB +: sfc_pkg::OFFSET_BITS];

   // Stage 1: one product per axis.
   assign px_in = PW'(nx) * PW'(center_x);
   assign py_in = PW'(ny) * PW'(center_y);
   assign pz_in = PW'(nz) * PW'(center_z);

   // Stage 2: exact signed distance with 14 fraction bits.
   assign dist_in = DW'(px_ff) + DW'(py_ff) + DW'(pz_ff)
                  + (DW'(off) <<< sfc_pkg::SCALE_SHIFT);

   // Stage 3: compare against plus and minus the scaled radius.
   assign r_pos = DW'({1'b0, radius_s2, {sfc_pkg::SCALE_SHIFT{1'b0}}});
   assign r_neg = -r_pos;
   assign reject_in  = tested_s2 && (dist_ff < r_neg);
   assign partial_in = tested_s2 && !(dist_ff < r_neg) && (dist_ff < r_pos);

   always_ff @(posedge clock) begin
      if (stage_en.s1_en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
      if (stage_en.s2_en) begin
         dist_ff <= dist_in;
      end
      if (stage_en.s3_en) begin
         reject_ff  <= reject_in;
         partial_ff <= partial_in;
      end
   end

   // The radius width must stay inside the distance width for the compare.
   if (RW > DW) begin : g_width_check
      $error("sfc_plane_lane: distance width too narrow for the radius");
   end

endmodule

`default_nettype wire

FILE: sv/sphere_frustum_cull_masked_unit.sv
// Sphere versus frustum classifier with plane masking, top level.
// Depends on sfc_pkg and sfc_plane_lane.
//
// Usage: the csr_ channel writes the packed frustum planes, one 64-bit register
// per index; indexes past the last plane are ignored. Writes are taken every
// cycle and should only be issued while no transaction is in flight.
// Each req_ transaction carries one sphere (center, radius), the mask of planes
// still to test and the preferred rejecting plane. Each produces exactly one
// rsp_ transaction: inside, partial or outside, the partial or echoed mask and
// the rejecting plane index, or the echoed start plane when nothing rejects.
// The datapath has four register stages: products, distance sum, radius compare
// and result selection; rsp_valid is the registered valid of the last stage.
// One sphere is accepted every cycle while the pipeline is not full.
// When the receiver holds rsp_ready low, the stages behind the output fill in
// turn and req_ready drops only once every stage holds a transaction; nothing
// is dropped or repeated. Reset clears the plane registers to zero and empties
// the pipeline.
`default_nettype none

module sphere_frustum_cull_masked_unit #(
   parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF,
   parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Configuration channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [sfc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire [sfc_pkg::PLANE_BITS-1:0]         csr_data,
   // Request channel
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire signed [COORD_BITS-1:0]           req_center_x,
   input  wire signed [COORD_BITS-1:0]           req_center_y,
   input  wire signed [COORD_BITS-1:0]           req_center_z,
   input  wire [sfc_pkg::RADIUS_BITS-1:0]        req_radius,
   input  wire [sfc_pkg::MASK_BITS-1:0]          req_in_mask,
   input  wire [sfc_pkg::PLANE_IDX_BITS-1:0]     req_start_plane,
   // Response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [1:0]                            rsp_cull_result,
   output logic [sfc_pkg::MASK_BITS-1:0]         rsp_out_mask,
   output logic [sfc_pkg::PLANE_IDX_BITS-1:0]    rsp_out_start_plane
);

   logic [sfc_pkg::PLANE_BITS-1:0] plane_ff [NUM_PLANES];

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv4;
   sfc_pkg::stage_en_type stage_en;

   logic [sfc_pkg::RADIUS_BITS-1:0]    radius_s1_ff, radius_s2_ff;
   logic [sfc_pkg::MASK_BITS-1:0]      mask_s1_ff, mask_s2_ff, mask_s3_ff;
   logic [sfc_pkg::PLANE_IDX_BITS-1:0] start_s1_ff, start_s2_ff, start_s3_ff;

   logic [NUM_PLANES-1:0]         lane_reject, lane_partial;
   logic [sfc_pkg::MASK_BITS-1:0] reject_all, partial_all;

   logic [1:0]                         result_in, result_ff;
   logic [sfc_pkg::MASK_BITS-1:0]      omask_in, omask_ff;
   logic [sfc_pkg::PLANE_IDX_BITS-1:0] ostart_in, ostart_ff;
   logic [sfc_pkg::PLANE_IDX_BITS-1:0] lowest_idx;
   logic                               start_rejects;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      always_ff @(posedge clock) begin
         if (reset) begin
            plane_ff[p] <= '0;
         end else if (csr_valid && (csr_index == sfc_pkg::CSR_IDX_BITS'(p))) begin
            plane_ff[p] <= csr_data;
         end
      end

      sfc_plane_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock      (clock),
         .stage_en   (stage_en),
         .plane      (plane_ff[p]),
         .center_x   (req_center_x),
         .center_y   (req_center_y),
         .center_z   (req_center_z),
         .radius_s2  (radius_s2_ff),
         .tested_s2  (mask_s2_ff[p]),
         .reject_ff  (lane_reject[p]),
         .partial_ff (lane_partial[p])
      );
   end

   // A stage loads when it is empty or its content moves on.
   assign adv4 = !rsp_valid_ff || rsp_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   assign stage_en.s1_en = adv1;
   assign stage_en.s2_en = adv2;
   assign stage_en.s3_en = adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff        <= req_valid;
         if (adv2) v2_ff        <= v1_ff;
         if (adv3) v3_ff        <= v2_ff;
         if (adv4) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         radius_s1_ff <= req_radius;
         mask_s1_ff   <= req_in_mask;
         start_s1_ff  <= req_start_plane;
      end
      if (adv2) begin
         radius_s2_ff <= radius_s1_ff;
         mask_s2_ff   <= mask_s1_ff;
         start_s2_ff  <= start_s1_ff;
      end
      if (adv3) begin
         mask_s3_ff   <= mask_s2_ff;
         start_s3_ff  <= start_s2_ff;
      end
      if (adv4) begin
         result_ff    <= result_in;
         omask_ff     <= omask_in;
         ostart_ff    <= ostart_in;
      end
   end

   // Stage 4: pick the classification and the rejecting plane.
   assign reject_all  = sfc_pkg::MASK_BITS'(lane_reject);
   assign partial_all = sfc_pkg::MASK_BITS'(lane_partial);

   always_comb begin
      lowest_idx = '0;
      for (int i = NUM_PLANES - 1; i >= 0; i--) begin
         if (reject_all[i]) begin
            lowest_idx = sfc_pkg::PLANE_IDX_BITS'(i);
         end
      end
   end

   // A start plane past the last plane never counts as the rejecting one.
   assign start_rejects = (start_s3_ff < sfc_pkg::PLANE_IDX_BITS'(NUM_PLANES))
                          && ((reject_all >> start_s3_ff) & 6'd1) != 6'd0;

   always_comb begin
      if (reject_all != '0) begin
         result_in = sfc_pkg::RES_OUTSIDE;
         omask_in  = mask_s3_ff;
         ostart_in = start_rejects ? start_s3_ff : lowest_idx;
      end else begin
         result_in = (partial_all != '0) ? sfc_pkg::RES_PARTIAL : sfc_pkg::RES_INSIDE;
         omask_in  = partial_all;
         ostart_in = start_s3_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cull_result     = result_ff;
   assign rsp_out_mask        = omask_ff;
   assign rsp_out_start_plane = ostart_ff;

   // An outside result always names an existing plane.
   a_outside_plane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff == sfc_pkg::RES_OUTSIDE)
         |-> (ostart_ff < sfc_pkg::PLANE_IDX_BITS'(NUM_PLANES)))
      else $error("outside result names a plane that does not exist");

   // Inside means no plane was found partial.
   a_inside_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff == sfc_pkg::RES_INSIDE) |-> (omask_ff == '0))
      else $error("inside result carries a nonzero mask");

   // Partial means at least one existing plane is flagged and no absent one.
   a_partial_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff == sfc_pkg::RES_PARTIAL)
         |-> (omask_ff != '0) && ((omask_ff >> NUM_PLANES) == '0))
      else $error("partial result mask is empty or names an absent plane");

   // A transaction accepted while every stage is free reaches rsp_valid without waiting.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !v1_ff && !v2_ff && !v3_ff && !rsp_valid_ff)
         |-> ##4 rsp_valid_ff)
      else $error("response did not appear after the pipeline latency");

endmodule

`default_nettype wire

FILE: bench/tb_sphere_frustum_cull_masked_unit.sv
// Self-checking testbench for sphere_frustum_cull_masked_unit: directed table, then
// random spheres. Depends on sfc_pkg and the unit; results are checked against typed
// expected verdicts or an in-bench classifier.
`timescale 1ns / 1ps

module tb_sphere_frustum_cull_masked_unit;

   localparam int NUM_PLANES       = sfc_pkg::NUM_PLANES_DEF;
   localparam int COORD_BITS       = sfc_pkg::COORD_BITS_DEF;
   localparam int MAX_PLANES       = sfc_pkg::MAX_PLANES;
   localparam int MASK_BITS        = sfc_pkg::MASK_BITS;
   localparam int PLANE_IDX_BITS   = sfc_pkg::PLANE_IDX_BITS;
   localparam int RADIUS_BITS      = sfc_pkg::RADIUS_BITS;
   localparam int PLANE_BITS       = sfc_pkg::PLANE_BITS;
   localparam int NORMAL_BITS      = sfc_pkg::NORMAL_BITS;
   localparam int OFFSET_BITS      = sfc_pkg::OFFSET_BITS;
   localparam int CSR_IDX_BITS     = sfc_pkg::CSR_IDX_BITS;
   localparam int SCALE_SHIFT      = sfc_pkg::SCALE_SHIFT;
   localparam int NX_LSB           = sfc_pkg::NX_LSB;
   localparam int NY_LSB           = sfc_pkg::NY_LSB;
   localparam int NZ_LSB           = sfc_pkg::NZ_LSB;
   localparam int OFF_LSB          = sfc_pkg::OFF_LSB;
   localparam logic [1:0] RES_INSIDE  = sfc_pkg::RES_INSIDE;
   localparam logic [1:0] RES_PARTIAL = sfc_pkg::RES_PARTIAL;
   localparam logic [1:0] RES_OUTSIDE = sfc_pkg::RES_OUTSIDE;

   localparam int RANDOM_PER_PHASE = 262;
   localparam int HOLDOFF_CYCLES   = 48;
   localparam int DRAIN_CYCLES     = 10;
   localparam int TIMEOUT_NS       = 4000000;

   localparam int CMAX = 8388607;
   localparam int CMIN = -8388608;
   localparam int RMAX = 8388607;

   // Indexes past the last plane register; writes there must be ignored.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [PLANE_BITS-1:0] PLANE_MAX = {12'h7ff, 12'h7ff, 12'h7ff, 28'h7ffffff};
   localparam logic [PLANE_BITS-1:0] PLANE_MIN = {12'h800, 12'h800, 12'h800, 28'h8000000};
   localparam logic [PLANE_BITS-1:0] PLANE_NEG_OFF = 64'h0000_0000_0fff_ffff;
   localparam logic [PLANE_BITS-1:0] PLANE_POS_OFF = 64'h0000_0000_0000_0001;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] center_z;
      logic [RADIUS_BITS-1:0]       radius;
      logic [MASK_BITS-1:0]         in_mask;
      logic [PLANE_IDX_BITS-1:0]    start_plane;
   } sphere_type;

   typedef struct packed {
      logic [1:0]                cull_result;
      logic [MASK_BITS-1:0]      result_mask;
      logic [PLANE_IDX_BITS-1:0] out_start_plane;
   } verdict_type;

   typedef enum logic [1:0] {ROW_SPHERE, ROW_ALL_PLANES, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_IDX_BITS-1:0] csr_index;
      logic [PLANE_BITS-1:0]   csr_data;
      sphere_type              sphere;
      logic                    typed;
      verdict_type             verdict;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [PLANE_BITS-1:0]     csr_data;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_BITS-1:0] req_center_x;
   logic signed [COORD_BITS-1:0] req_center_y;
   logic signed [COORD_BITS-1:0] req_center_z;
   logic [RADIUS_BITS-1:0]    req_radius;
   logic [MASK_BITS-1:0]      req_in_mask;
   logic [PLANE_IDX_BITS-1:0] req_start_plane;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [1:0]                rsp_cull_result;
   logic [MASK_BITS-1:0]      rsp_out_mask;
   logic [PLANE_IDX_BITS-1:0] rsp_out_start_plane;

   logic [PLANE_BITS-1:0] plane_shadow [MAX_PLANES];
   verdict_type           expected_verdicts [$];
   stim_row_type          directed_rows [$];
   int                    mismatch_count = 0;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   logic                  holdoff_request = 1'b0;
   int                    holdoff_left = 0;

   sphere_frustum_cull_masked_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_center_x        (req_center_x),
      .req_center_y        (req_center_y),
      .req_center_z        (req_center_z),
      .req_radius          (req_radius),
      .req_in_mask         (req_in_mask),
      .req_start_plane     (req_start_plane),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cull_result     (rsp_cull_result),
      .rsp_out_mask        (rsp_out_mask),
      .rsp_out_start_plane (rsp_out_start_plane)
   );

   // Distances are formed exactly with 14 fraction bits, as the hardware does.
   function automatic verdict_type classify_sphere(input sphere_type s);
      verdict_type          v;
      longint               cx, cy, cz, rad, nx, ny, nz, off, plane_dist;
      logic [MASK_BITS-1:0] reject, partial;
      int                   i;
      cx = $signed(s.center_x);
      cy = $signed(s.center_y);
      cz = $signed(s.center_z);
      rad = s.radius;
      rad = rad * (1 << SCALE_SHIFT);
      reject = '0;
      partial = '0;
      for (i = 0; i < NUM_PLANES; i++) begin
         if (s.in_mask[i]) begin
            nx = $signed(plane_shadow[i][NX_LSB +: NORMAL_BITS]);
            ny = $signed(plane_shadow[i][NY_LSB +: NORMAL_BITS]);
            nz = $signed(plane_shadow[i][NZ_LSB +: NORMAL_BITS]);
            off = $signed(plane_shadow[i][OFF_LSB +: OFFSET_BITS]);
            plane_dist = nx * cx + ny * cy + nz * cz + off * (1 << SCALE_SHIFT);
            if (plane_dist < -rad) begin
               reject[i] = 1'b1;
            end else if (plane_dist < rad) begin
               partial[i] = 1'b1;
            end
         end
      end
      if (reject != '0) begin
         v.cull_result = RES_OUTSIDE;
         v.result_mask = s.in_mask;
         if (s.start_plane < NUM_PLANES && reject[s.start_plane]) begin
            v.out_start_plane = s.start_plane;
         end else begin
            v.out_start_plane = '0;
            for (i = MASK_BITS - 1; i >= 0; i--) begin
               if (reject[i]) v.out_start_plane = i[PLANE_IDX_BITS-1:0];
            end
         end
      end else begin
         v.cull_result = (partial != '0) ? RES_PARTIAL : RES_INSIDE;
         v.result_mask = partial;
         v.out_start_plane = s.start_plane;
      end
      return v;
   endfunction

   function automatic stim_row_type sphere_row(input int cx, input int cy, input int cz,
                                               input int rad, input logic [MASK_BITS-1:0] mask,
                                               input logic [PLANE_IDX_BITS-1:0] start,
                                               input int typed, input logic [1:0] res,
                                               input logic [MASK_BITS-1:0] omask,
                                               input logic [PLANE_IDX_BITS-1:0] ostart);
      stim_row_type r;
      r = '0;
      r.kind = ROW_SPHERE;
      r.sphere.center_x = cx[COORD_BITS-1:0];
      r.sphere.center_y = cy[COORD_BITS-1:0];
      r.sphere.center_z = cz[COORD_BITS-1:0];
      r.sphere.radius = rad[RADIUS_BITS-1:0];
      r.sphere.in_mask = mask;
      r.sphere.start_plane = start;
      r.typed = (typed != 0);
      r.verdict.cull_result = res;
      r.verdict.result_mask = omask;
      r.verdict.out_start_plane = ostart;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input row_kind_type kind,
                                            input logic [CSR_IDX_BITS-1:0] idx,
                                            input logic [PLANE_BITS-1:0] data);
      stim_row_type r;
      r = '0;
      r.kind = kind;
      r.csr_index = idx;
      r.csr_data = data;
      return r;
   endfunction

   // Style 0 is fully random, 1 keeps the offset small, 2 picks an extreme or a random plane.
   function automatic logic [PLANE_BITS-1:0] random_plane(input int style);
      logic [PLANE_BITS-1:0] p;
      int                    off;
      p = {$urandom, $urandom};
      if (style == 1) begin
         off = $urandom_range(32767) - 16384;
         p[OFF_LSB +: OFFSET_BITS] = off[OFFSET_BITS-1:0];
      end else if (style == 2) begin
         case ($urandom_range(4))
            0: p = '0;
            1: p = '1;
            2: p = PLANE_MAX;
            3: p = PLANE_MIN;
            default: p = {$urandom, $urandom};
         endcase
      end
      return p;
   endfunction

   function automatic logic [COORD_BITS-1:0] random_coord();
      int v;
      if ($urandom_range(3) == 0) begin
         v = $urandom;
      end else begin
         v = $urandom_range(32767) - 16384;
      end
      return v[COORD_BITS-1:0];
   endfunction

   function automatic sphere_type random_sphere();
      sphere_type s;
      int         rad;
      s.center_x = random_coord();
      s.center_y = random_coord();
      s.center_z = random_coord();
      case ($urandom_range(5))
         0: rad = 0;
         1, 2: rad = $urandom;
         default: rad = $urandom_range(4095);
      endcase
      s.radius = rad[RADIUS_BITS-1:0];
      s.in_mask = ($urandom_range(1) == 0) ? {MASK_BITS{1'b1}} : MASK_BITS'($urandom);
      s.start_plane = PLANE_IDX_BITS'($urandom_range(7));
      return s;
   endfunction

   task automatic send_sphere(input sphere_type s, input verdict_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_center_x = s.center_x;
      req_center_y = s.center_y;
      req_center_z = s.center_z;
      req_radius = s.radius;
      req_in_mask = s.in_mask;
      req_start_plane = s.start_plane;
      do @(posedge clock); while (!req_ready);
      expected_verdicts.push_back(v);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [PLANE_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      if (idx < MAX_PLANES) plane_shadow[idx] = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stop offering spheres and let every transaction in flight come out.
   task automatic wait_pipeline_empty();
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off when requested so the pipe fills.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_request = 1'b0;
         end
         if (holdoff_left > 0) begin
            rsp_ready = 1'b0;
            holdoff_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d/%0h/%0d", $time,
                     rsp_cull_result, rsp_out_mask, rsp_out_start_plane);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_cull_result !== want.cull_result) begin
               $display("%0t: cull_result mismatch, expected %0d, actual %0d", $time,
                        want.cull_result, rsp_cull_result);
               mismatch_count++;
            end
            if (rsp_out_mask !== want.result_mask) begin
               $display("%0t: result mask mismatch, expected %0h, actual %0h", $time,
                        want.result_mask, rsp_out_mask);
               mismatch_count++;
            end
            if (rsp_out_start_plane !== want.out_start_plane) begin
               $display("%0t: out_start_plane mismatch, expected %0d, actual %0d", $time,
                        want.out_start_plane, rsp_out_start_plane);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int           i, phase, n;
      sphere_type   s;
      stim_row_type row;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_center_x = '0;
      req_center_y = '0;
      req_center_z = '0;
      req_radius = '0;
      req_in_mask = '0;
      req_start_plane = '0;
      for (i = 0; i < MAX_PLANES; i++) plane_shadow[i] = '0;

      // Planes are all zero after reset, so a nonzero radius is partial on every tested plane.
      directed_rows.push_back(sphere_row(0, 0, 0, 0, 6'h3f, 3'd0, 1, RES_INSIDE, 6'h00, 3'd0));
      directed_rows.push_back(sphere_row(0, 0, 0, 1, 6'h3f, 3'd3, 1, RES_PARTIAL, 6'h3f, 3'd3));
      directed_rows.push_back(sphere_row(CMAX, CMAX, CMAX, RMAX, 6'h00, 3'd7, 1,
                                         RES_INSIDE, 6'h00, 3'd7));
      directed_rows.push_back(sphere_row(CMIN, CMIN, CMIN, RMAX, 6'h3f, 3'd6, 1,
                                         RES_PARTIAL, 6'h3f, 3'd6));
      directed_rows.push_back(sphere_row(CMAX, CMIN, CMAX, 1, 6'h15, 3'd5, 1,
                                         RES_PARTIAL, 6'h15, 3'd5));
      // Every plane at distance minus one from the origin rejects a point sphere.
      directed_rows.push_back(csr_row(ROW_ALL_PLANES, '0, PLANE_NEG_OFF));
      directed_rows.push_back(sphere_row(0, 0, 0, 0, 6'h3f, 3'd2, 1, RES_OUTSIDE, 6'h3f, 3'd2));
      directed_rows.push_back(sphere_row(0, 0, 0, 0, 6'h3f, 3'd7, 1, RES_OUTSIDE, 6'h3f, 3'd0));
      directed_rows.push_back(sphere_row(0, 0, 0, 0, 6'h30, 3'd1, 1, RES_OUTSIDE, 6'h30, 3'd4));
      directed_rows.push_back(sphere_row(0, 0, 0, 1, 6'h3f, 3'd1, 1, RES_PARTIAL, 6'h3f, 3'd1));
      directed_rows.push_back(sphere_row(0, 0, 0, 0, 6'h00, 3'd4, 1, RES_INSIDE, 6'h00, 3'd4));
      directed_rows.push_back(csr_row(ROW_CSR, CSR_SPARE_LO, '1));
      directed_rows.push_back(csr_row(ROW_CSR, CSR_SPARE_HI, '1));
      directed_rows.push_back(sphere_row(0, 0, 0, 0, 6'h3f, 3'd2, 1, RES_OUTSIDE, 6'h3f, 3'd2));
      // Plane three sits exactly at distance plus one radius: inside, not partial.
      directed_rows.push_back(csr_row(ROW_CSR, 3'd3, PLANE_POS_OFF));
      directed_rows.push_back(sphere_row(0, 0, 0, 1, 6'h08, 3'd3, 1, RES_INSIDE, 6'h00, 3'd3));
      directed_rows.push_back(sphere_row(0, 0, 0, 1, 6'h3f, 3'd0, 1, RES_PARTIAL, 6'h37, 3'd0));
      directed_rows.push_back(csr_row(ROW_ALL_PLANES, '0, '1));
      directed_rows.push_back(sphere_row(CMAX, CMAX, CMAX, 0, 6'h3f, 3'd0, 0, '0, '0, '0));
      directed_rows.push_back(sphere_row(CMIN, CMIN, CMIN, RMAX, 6'h3f, 3'd5, 0, '0, '0, '0));
      directed_rows.push_back(sphere_row(0, 0, 0, RMAX, 6'h3f, 3'd1, 0, '0, '0, '0));
      for (i = 0; i < MAX_PLANES; i++) begin
         directed_rows.push_back(csr_row(ROW_CSR, i[CSR_IDX_BITS-1:0],
                                         (i % 2 == 0) ? PLANE_MAX : PLANE_MIN));
      end
      directed_rows.push_back(sphere_row(CMAX, CMAX, CMAX, RMAX, 6'h3f, 3'd1, 0, '0, '0, '0));
      directed_rows.push_back(sphere_row(CMIN, CMIN, CMIN, 0, 6'h3f, 3'd3, 0, '0, '0, '0));
      directed_rows.push_back(sphere_row(CMAX, CMIN, 0, 12345, 6'h2a, 3'd4, 0, '0, '0, '0));
      directed_rows.push_back(sphere_row(CMIN, CMAX, CMIN, RMAX, 6'h15, 3'd6, 0, '0, '0, '0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         case (row.kind)
            ROW_SPHERE: begin
               send_sphere(row.sphere, row.typed ? row.verdict : classify_sphere(row.sphere));
            end
            ROW_ALL_PLANES: begin
               wait_pipeline_empty();
               for (i = 0; i < MAX_PLANES; i++) write_csr(i[CSR_IDX_BITS-1:0], row.csr_data);
            end
            default: begin
               wait_pipeline_empty();
               write_csr(row.csr_index, row.csr_data);
            end
         endcase
      end

      // Random phases: free flow, idle sender, stalling receiver, then both.
      for (phase = 0; phase < 4; phase++) begin
         wait_pipeline_empty();
         for (i = 0; i < MAX_PLANES; i++) begin
            write_csr(i[CSR_IDX_BITS-1:0],
                      random_plane((phase == 2) ? 2 : $urandom_range(1)));
         end
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 66; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == 60 && (phase == 0 || phase == 3)) holdoff_request = 1'b1;
            s = random_sphere();
            send_sphere(s, classify_sphere(s));
         end
      end

      wait_pipeline_empty();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sphere_frustum_cull_masked_unit.f
sv/sfc_pkg.sv
sv/sfc_plane_lane.sv
sv/sphere_frustum_cull_masked_unit.sv
bench/tb_sphere_frustum_cull_masked_unit.sv
